// File: rtl/dscr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscr_pkg
// Shared types and constants of the debounced switch CAN status reporter.
// ----------------------------------------------------------------------------
package dscr_pkg;

  localparam int unsigned RawW   = 13;
  localparam int unsigned ElapsW = 16;
  localparam int unsigned TimeW  = 22;
  localparam int unsigned FailW  = 4;
  localparam int unsigned NodeW  = 3;
  localparam int unsigned IdW    = 5;
  localparam int unsigned AddrW  = 3;

  localparam logic [IdW-1:0]   FrameBaseId     = 5'h0A;
  localparam logic [TimeW-1:0] TimeMax         = {TimeW{1'b1}};
  localparam logic [FailW-1:0] FailMax         = {FailW{1'b1}};
  localparam logic [TimeW-1:0] ActivePeriodRst = 22'd200000;
  localparam logic [TimeW-1:0] ProbePeriodRst  = 22'd2000000;
  localparam logic [TimeW-1:0] DebounceRst     = 22'd50000;
  localparam logic [FailW-1:0] FailThreshRst   = 4'd3;

  typedef enum logic [AddrW-1:0] {
    REG_NODE_ADDR     = 3'd0,
    REG_ACTIVE_PERIOD = 3'd1,
    REG_PROBE_PERIOD  = 3'd2,
    REG_DEBOUNCE      = 3'd3,
    REG_FAIL_THRESH   = 3'd4
  } dscr_reg_e;

  typedef struct packed {
    logic [NodeW-1:0] node_address;
    logic [TimeW-1:0] active_period_us;
    logic [TimeW-1:0] probe_period_us;
    logic [TimeW-1:0] debounce_us;
    logic [FailW-1:0] fail_threshold;
  } dscr_cfg_t;

  typedef struct packed {
    logic              alert_rx_data;
    logic              alert_tx_success;
    logic              alert_tx_failed;
    logic              alert_recovered;
    logic              alert_bus_off;
    logic [ElapsW-1:0] elapsed_us;
    logic [RawW-1:0]   raw_switches;
  } dscr_item_t;

  typedef struct packed {
    logic            restart_controller;
    logic            start_recovery;
    logic            bus_is_off;
    logic            probing;
    logic [RawW-1:0] debounced_switches;
    logic [4:0]      data_high;
    logic [7:0]      data_low;
    logic [IdW-1:0]  frame_id;
    logic            send_frame;
  } dscr_res_t;

endpackage

// File: rtl/dscr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscr_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module dscr_cfg import dscr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_addr_i,
  input  logic [TimeW-1:0] cfg_wdata_i,
  output dscr_cfg_t        cfg_o
);

  dscr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (dscr_reg_e'(cfg_addr_i))
        REG_NODE_ADDR:     cfg_d.node_address     = cfg_wdata_i[NodeW-1:0];
        REG_ACTIVE_PERIOD: cfg_d.active_period_us = cfg_wdata_i;
        REG_PROBE_PERIOD:  cfg_d.probe_period_us  = cfg_wdata_i;
        REG_DEBOUNCE:      cfg_d.debounce_us      = cfg_wdata_i;
        REG_FAIL_THRESH:   cfg_d.fail_threshold   = cfg_wdata_i[FailW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_address     <= '0;
      cfg_q.active_period_us <= ActivePeriodRst;
      cfg_q.probe_period_us  <= ProbePeriodRst;
      cfg_q.debounce_us      <= DebounceRst;
      cfg_q.fail_threshold   <= FailThreshRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/dscr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscr_core
// Poll step: debounce, transmit timer, mode tracking and bus-off handling.
// ----------------------------------------------------------------------------
module dscr_core import dscr_pkg::*; #(
  parameter int unsigned SWITCH_COUNT = 13
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  dscr_item_t item_i,
  input  dscr_cfg_t  cfg_i,
  output dscr_res_t  res_o
);

  localparam int unsigned SwW = (SWITCH_COUNT < RawW) ? SWITCH_COUNT : RawW;

  logic [SwW-1:0]   last_raw_q, last_raw_d;
  logic [SwW-1:0]   acc_q, acc_d;
  logic [TimeW-1:0] stable_q, stable_d;
  logic [TimeW-1:0] since_q, since_d;
  logic             probe_q, probe_d;
  logic [FailW-1:0] fail_q, fail_d;
  logic             bus_off_q, bus_off_d;
  logic             send, recover, restart;
  logic [RawW-1:0]  acc_word;

  always_comb begin
    logic [TimeW:0]   st_sum;
    logic [TimeW:0]   ss_sum;
    logic [SwW-1:0]   raw;
    logic [TimeW-1:0] period;
    logic [FailW-1:0] fail_inc;
    raw        = item_i.raw_switches[SwW-1:0];
    st_sum     = {1'b0, stable_q} + (TimeW+1)'(item_i.elapsed_us);
    ss_sum     = {1'b0, since_q} + (TimeW+1)'(item_i.elapsed_us);
    stable_d   = st_sum[TimeW] ? TimeMax : st_sum[TimeW-1:0];
    since_d    = ss_sum[TimeW] ? TimeMax : ss_sum[TimeW-1:0];
    last_raw_d = last_raw_q;
    acc_d      = acc_q;
    probe_d    = probe_q;
    fail_d     = fail_q;
    bus_off_d  = bus_off_q;
    send       = 1'b0;
    recover    = 1'b0;
    restart    = 1'b0;
    period     = cfg_i.active_period_us;
    fail_inc   = (fail_q == FailMax) ? FailMax : fail_q + 1'b1;
    if (item_i.alert_bus_off) begin
      bus_off_d = 1'b1;
      recover   = 1'b1;
    end else begin
      if (item_i.alert_recovered) begin
        restart   = 1'b1;
        bus_off_d = 1'b0;
        fail_d    = '0;
        probe_d   = 1'b1;
      end
      if (item_i.alert_tx_failed && !probe_d) begin
        fail_inc = (fail_d == FailMax) ? FailMax : fail_d + 1'b1;
        fail_d   = fail_inc;
        if (fail_inc >= cfg_i.fail_threshold) probe_d = 1'b1;
      end
      if (item_i.alert_tx_success) begin
        probe_d = 1'b0;
        fail_d  = '0;
      end
      if (item_i.alert_rx_data && probe_d) begin
        probe_d = 1'b0;
        fail_d  = '0;
      end
      if (raw != last_raw_q) begin
        last_raw_d = raw;
        stable_d   = '0;
      end
      if (stable_d >= cfg_i.debounce_us) acc_d = last_raw_d;
      period = probe_d ? cfg_i.probe_period_us : cfg_i.active_period_us;
      if (!bus_off_d && since_d >= period) begin
        send    = 1'b1;
        since_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '0;
      acc_q      <= '0;
      stable_q   <= '0;
      since_q    <= TimeMax;
      probe_q    <= 1'b0;
      fail_q     <= '0;
      bus_off_q  <= 1'b0;
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      acc_q      <= acc_d;
      stable_q   <= stable_d;
      since_q    <= since_d;
      probe_q    <= probe_d;
      fail_q     <= fail_d;
      bus_off_q  <= bus_off_d;
    end
  end

  assign acc_word = RawW'(acc_d);

  always_comb begin
    res_o.send_frame         = send;
    res_o.frame_id           = FrameBaseId + IdW'(cfg_i.node_address);
    res_o.data_low           = acc_word[7:0];
    res_o.data_high          = acc_word[12:8];
    res_o.debounced_switches = acc_word;
    res_o.probing            = probe_d;
    res_o.bus_is_off         = bus_off_d;
    res_o.start_recovery     = recover;
    res_o.restart_controller = restart;
  end

endmodule

// File: rtl/debounced_switch_can_reporter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_switch_can_reporter_unit
// Debounced switch status reporter with CAN transmit-mode tracking.
// ----------------------------------------------------------------------------
// dataflow: an accepted request is held in the input register, then the step
//   output is captured in the result register once the output side can take it
// throughput: one request per cycle while m_axis_tready does not stall the output
// reset: asynchronous active low; clears mode state, sets the transmit timer
//   to its maximum so the first eligible poll sends, loads register defaults
module debounced_switch_can_reporter_unit import dscr_pkg::*; #(
  parameter int unsigned SWITCH_COUNT = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // raw_switches, elapsed_us, alert_bus_off, alert_recovered, alert_tx_failed,
  // alert_tx_success, alert_rx_data, zero fill
  input  logic [39:0]      s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // send_frame, frame_id, data_low, data_high, debounced_switches, probing,
  // bus_is_off, start_recovery, restart_controller, zero fill
  output logic [39:0]      m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_addr_i,
  input  logic [TimeW-1:0] cfg_wdata_i
);

  localparam int unsigned ItemW = $bits(dscr_item_t);
  localparam int unsigned ResW  = $bits(dscr_res_t);

  dscr_cfg_t  cfg;
  dscr_item_t item_q;
  dscr_res_t  res, res_q;
  logic       in_valid_q, out_valid_q;
  logic       advance, s_accept;

  dscr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dscr_core #(
    .SWITCH_COUNT (SWITCH_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) item_q <= dscr_item_t'(s_axis_tdata[ItemW-1:0]);
    if (advance)  res_q  <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(40-ResW){1'b0}}, res_q};

`ifndef SYNTH
  a_send_not_bus_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.send_frame |-> !res_q.bus_is_off)
    else $error("frame requested while bus-off");

  a_recovery_bus_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.start_recovery |-> res_q.bus_is_off && !res_q.send_frame)
    else $error("recovery requested without bus-off");

  a_restart_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.restart_controller |-> !res_q.start_recovery)
    else $error("restart and recovery in one poll");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && in_valid_q |-> advance)
    else $error("input register overwritten before step");
`endif

endmodule
